[rtl/vt52td_pkg.sv]
package vt52td_pkg;

    typedef enum logic [3:0] {
        CMD_NONE        = 4'd0,
        CMD_GLYPH       = 4'd1,
        CMD_ERASE_SPAN  = 4'd2,
        CMD_ERASE_LINES = 4'd3,
        CMD_SCROLL_UP   = 4'd4,
        CMD_SCROLL_DOWN = 4'd5,
        CMD_INS_LINE    = 4'd6,
        CMD_DEL_LINE    = 4'd7,
        CMD_CLEAR_SCR   = 4'd8,
        CMD_BELL        = 4'd9,
        CMD_CLEAR_LINE  = 4'd10
    } cmd_t;

    typedef struct packed {
        cmd_t       command;
        logic [7:0] row_first;
        logic [7:0] row_last;
        logic [7:0] col_first;
        logic [7:0] col_last;
        logic [7:0] glyph;
        logic [7:0] cursor_col;
        logic [7:0] cursor_row;
        logic       reverse_video;
        logic       cursor_hidden;
        logic       last;
    } result_t;

    // up to two commands per character
    typedef struct packed {
        result_t first;
        result_t second;
        logic    two;
    } step_out_t;

    typedef struct packed {
        logic       we;
        logic [1:0] index;
        logic [7:0] data;
    } cfg_wr_t;

    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;

    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [7:0] ROWS_RESET = 8'd25;

    localparam logic [7:0] CH_BEL   = 8'd7;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_HT    = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_DEL   = 8'd127;

    localparam logic [7:0] ESC_UP        = 8'h41;
    localparam logic [7:0] ESC_DOWN      = 8'h42;
    localparam logic [7:0] ESC_RIGHT     = 8'h43;
    localparam logic [7:0] ESC_LEFT      = 8'h44;
    localparam logic [7:0] ESC_CLEAR     = 8'h45;
    localparam logic [7:0] ESC_HOME      = 8'h48;
    localparam logic [7:0] ESC_REV_LF    = 8'h49;
    localparam logic [7:0] ESC_ERASE_EOS = 8'h4A;
    localparam logic [7:0] ESC_ERASE_EOL = 8'h4B;
    localparam logic [7:0] ESC_INS_LINE  = 8'h4C;
    localparam logic [7:0] ESC_DEL_LINE  = 8'h4D;
    localparam logic [7:0] ESC_ADDR      = 8'h59;
    localparam logic [7:0] ESC_FG        = 8'h62;
    localparam logic [7:0] ESC_BG        = 8'h63;
    localparam logic [7:0] ESC_ERASE_BOS = 8'h64;
    localparam logic [7:0] ESC_SHOW      = 8'h65;
    localparam logic [7:0] ESC_HIDE      = 8'h66;
    localparam logic [7:0] ESC_SAVE      = 8'h6A;
    localparam logic [7:0] ESC_RESTORE   = 8'h6B;
    localparam logic [7:0] ESC_CLR_LINE  = 8'h6C;
    localparam logic [7:0] ESC_ERASE_BOL = 8'h6F;
    localparam logic [7:0] ESC_REV_ON    = 8'h70;
    localparam logic [7:0] ESC_REV_OFF   = 8'h71;
    localparam logic [7:0] ESC_WRAP      = 8'h76;
    localparam logic [7:0] ESC_NOWRAP    = 8'h77;

endpackage

[rtl/vt52_terminal_decoder_unit.sv]
// channel  direction  handshake                  payload
// in       to block   in_valid / in_stall         char_code
// out      from block out_valid / out_stall       command .. last (one word per command)
// cfg      to block   cfg_valid / cfg_ready       cfg_index, cfg_data
//
// A character is captured in the input register and decoded into the result register,
// from which its first word is driven.
// One character per cycle while out_stall is low and it yields one word; a glyph that
// scrolls, ESC J and ESC d can yield two words; the second waits in a pending register.
// Reset: cursor and saved cursor at 0, plain state, flags clear, 80 columns, 25 rows.
// out_stall holds both words; in_stall rises once the input register cannot drain.
module vt52_terminal_decoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] command,
    output logic [7:0] row_first,
    output logic [7:0] row_last,
    output logic [7:0] col_first,
    output logic [7:0] col_last,
    output logic [7:0] glyph,
    output logic [7:0] cursor_col,
    output logic [7:0] cursor_row,
    output logic       reverse_video,
    output logic       cursor_hidden,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic                  in_full_reg;
    logic [7:0]            char_reg;
    logic                  out_full_reg, pend_full_reg;
    vt52td_pkg::result_t   out_reg, pend_reg;
    vt52td_pkg::step_out_t step;
    vt52td_pkg::cfg_wr_t   cfg;
    logic                  out_free, step_en;

    assign out_free  = !out_full_reg || (!out_stall && !pend_full_reg);
    assign step_en   = in_full_reg && out_free;
    assign in_stall  = in_full_reg && !step_en;
    assign cfg_ready = !in_full_reg;

    assign cfg.we    = cfg_valid && cfg_ready;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    vt52td_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .char_code (char_reg),
        .cfg       (cfg),
        .res       (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_full_reg  <= 1'b0;
            pend_full_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_full_reg <= in_valid;
            if (step_en)
            begin
                out_full_reg  <= 1'b1;
                pend_full_reg <= step.two;
            end
            else if (out_full_reg && !out_stall)
            begin
                // advance the second word or drop the last
                if (pend_full_reg)
                    pend_full_reg <= 1'b0;
                else
                    out_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
            char_reg <= char_code;
        if (step_en)
        begin
            out_reg  <= step.first;
            pend_reg <= step.second;
        end
        else if (out_full_reg && !out_stall && pend_full_reg)
            out_reg <= pend_reg;
    end

    assign out_valid     = out_full_reg;
    assign command       = out_reg.command;
    assign row_first     = out_reg.row_first;
    assign row_last      = out_reg.row_last;
    assign col_first     = out_reg.col_first;
    assign col_last      = out_reg.col_last;
    assign glyph         = out_reg.glyph;
    assign cursor_col    = out_reg.cursor_col;
    assign cursor_row    = out_reg.cursor_row;
    assign reverse_video = out_reg.reverse_video;
    assign cursor_hidden = out_reg.cursor_hidden;
    assign last          = out_reg.last;

    a_pend_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_full_reg |-> out_full_reg)
        else $error("second word held without a first");

    a_not_last_has_pend: assert property (@(posedge clk) disable iff (!rst_n)
        out_full_reg && !out_reg.last |-> pend_full_reg)
        else $error("word marked not last with nothing behind it");

    a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> out_full_reg)
        else $error("decoded character left no word");

    a_cfg_excl_step: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !step_en)
        else $error("register write while a character decodes");

endmodule

[rtl/vt52td_core.sv]
module vt52td_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  logic [7:0]            char_code,
    input  vt52td_pkg::cfg_wr_t   cfg,
    output vt52td_pkg::step_out_t res
);

    typedef enum logic [2:0] {
        PH_PLAIN = 3'd0,
        PH_ESC   = 3'd1,
        PH_ARGS  = 3'd2,
        PH_FG    = 3'd3,
        PH_BG    = 3'd4
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [1:0] argcnt_reg, argcnt_next;
    logic [7:0] col_reg, row_reg, saved_col_reg, saved_row_reg;
    logic [7:0] col_next, row_next, saved_col_next, saved_row_next;
    logic       hide_reg, hide_next, rev_reg, rev_next, disc_reg, disc_next;
    logic [7:0] columns_reg, rows_reg;

    logic [7:0] nc, nr, cfg_dim;
    logic [8:0] nc9, nr9, cx, cy, tab;
    vt52td_pkg::result_t e0, e1, fin, s0, s1;
    logic       e0_v, e1_v, fs_v;

    function automatic vt52td_pkg::result_t mk(input vt52td_pkg::cmd_t c,
                                               input logic [7:0] r0, input logic [7:0] r1,
                                               input logic [7:0] c0, input logic [7:0] c1,
                                               input logic [7:0] g);
        vt52td_pkg::result_t r;
        r = '0;
        r.command   = c;
        r.row_first = r0;
        r.row_last  = r1;
        r.col_first = c0;
        r.col_last  = c1;
        r.glyph     = g;
        return r;
    endfunction

    function automatic logic [7:0] clamp_arg(input logic [7:0] ch, input logic [7:0] dim);
        logic [7:0] v;
        v = (ch < vt52td_pkg::CH_SPACE) ? 8'd0 : ch - vt52td_pkg::CH_SPACE;
        return (v >= dim) ? dim - 8'd1 : v;
    endfunction

    assign nc      = (columns_reg == 8'd0) ? 8'd1 : columns_reg;
    assign nr      = (rows_reg == 8'd0) ? 8'd1 : rows_reg;
    assign nc9     = {1'b0, nc};
    assign nr9     = {1'b0, nr};
    assign cfg_dim = (cfg.data == 8'd0) ? 8'd1 : cfg.data;

    always_comb
    begin
        phase_next     = phase_reg;
        argcnt_next    = argcnt_reg;
        saved_col_next = saved_col_reg;
        saved_row_next = saved_row_reg;
        hide_next      = hide_reg;
        rev_next       = rev_reg;
        disc_next      = disc_reg;
        cx             = {1'b0, col_reg};
        cy             = {1'b0, row_reg};
        tab            = {cx[8:3] + 6'd1, 3'b000};
        e0             = '0;
        e1             = '0;
        e0_v           = 1'b0;
        e1_v           = 1'b0;
        fs_v           = 1'b0;

        if (phase_reg != PH_PLAIN)
        begin
            unique case (phase_reg)
                PH_ARGS:
                begin
                    argcnt_next = argcnt_reg + 2'd1;
                    if (argcnt_next == 2'd1)
                        cy = {1'b0, clamp_arg(char_code, nr)};
                    else if (argcnt_next == 2'd2)
                    begin
                        cx         = {1'b0, clamp_arg(char_code, nc)};
                        phase_next = PH_PLAIN;
                    end
                    else
                        phase_next = PH_PLAIN;
                end
                PH_ESC:
                begin
                    phase_next = PH_PLAIN;
                    unique case (char_code)
                        vt52td_pkg::ESC_UP:    if (cy != 9'd0) cy = cy - 9'd1;
                        vt52td_pkg::ESC_DOWN:  if (cy + 9'd1 < nr9) cy = cy + 9'd1;
                        vt52td_pkg::ESC_RIGHT: if (cx + 9'd1 < nc9) cx = cx + 9'd1;
                        vt52td_pkg::ESC_LEFT:  if (cx != 9'd0) cx = cx - 9'd1;
                        vt52td_pkg::ESC_CLEAR:
                        begin
                            cx   = 9'd0;
                            cy   = 9'd0;
                            e0   = mk(vt52td_pkg::CMD_CLEAR_SCR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                            e0_v = 1'b1;
                        end
                        vt52td_pkg::ESC_HOME:
                        begin
                            cx = 9'd0;
                            cy = 9'd0;
                        end
                        vt52td_pkg::ESC_REV_LF:
                        begin
                            if (cy != 9'd0)
                                cy = cy - 9'd1;
                            else
                            begin
                                e0   = mk(vt52td_pkg::CMD_SCROLL_DOWN,
                                          8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                                e0_v = 1'b1;
                            end
                        end
                        vt52td_pkg::ESC_ERASE_EOS:
                        begin
                            if (cy + 9'd1 < nr9)
                            begin
                                e0   = mk(vt52td_pkg::CMD_ERASE_LINES, cy[7:0] + 8'd1,
                                          nr - 8'd1, 8'd0, 8'd0, 8'd0);
                                e0_v = 1'b1;
                            end
                            if (cx < nc9)
                            begin
                                e1   = mk(vt52td_pkg::CMD_ERASE_SPAN, cy[7:0], 8'd0,
                                          cx[7:0], nc - 8'd1, 8'd0);
                                e1_v = 1'b1;
                            end
                        end
                        vt52td_pkg::ESC_ERASE_EOL:
                        begin
                            if (cx < nc9)
                            begin
                                e0   = mk(vt52td_pkg::CMD_ERASE_SPAN, cy[7:0], 8'd0,
                                          cx[7:0], nc - 8'd1, 8'd0);
                                e0_v = 1'b1;
                            end
                        end
                        vt52td_pkg::ESC_INS_LINE:
                        begin
                            e0   = mk(vt52td_pkg::CMD_INS_LINE, cy[7:0], 8'd0, 8'd0, 8'd0, 8'd0);
                            e0_v = 1'b1;
                            cx   = 9'd0;
                        end
                        vt52td_pkg::ESC_DEL_LINE:
                        begin
                            e0   = mk(vt52td_pkg::CMD_DEL_LINE, cy[7:0], 8'd0, 8'd0, 8'd0, 8'd0);
                            e0_v = 1'b1;
                            cx   = 9'd0;
                        end
                        vt52td_pkg::ESC_ADDR:
                        begin
                            phase_next  = PH_ARGS;
                            argcnt_next = 2'd0;
                        end
                        vt52td_pkg::ESC_FG:
                        begin
                            phase_next  = PH_FG;
                            argcnt_next = 2'd0;
                        end
                        vt52td_pkg::ESC_BG:
                        begin
                            phase_next  = PH_BG;
                            argcnt_next = 2'd0;
                        end
                        vt52td_pkg::ESC_ERASE_BOS:
                        begin
                            if (cy != 9'd0)
                            begin
                                e0   = mk(vt52td_pkg::CMD_ERASE_LINES, 8'd0,
                                          cy[7:0] - 8'd1, 8'd0, 8'd0, 8'd0);
                                e0_v = 1'b1;
                            end
                            if (cx != 9'd0)
                            begin
                                e1   = mk(vt52td_pkg::CMD_ERASE_SPAN, cy[7:0], 8'd0,
                                          8'd0, cx[7:0] - 8'd1, 8'd0);
                                e1_v = 1'b1;
                            end
                        end
                        vt52td_pkg::ESC_ERASE_BOL:
                        begin
                            if (cx != 9'd0)
                            begin
                                e0   = mk(vt52td_pkg::CMD_ERASE_SPAN, cy[7:0], 8'd0,
                                          8'd0, cx[7:0] - 8'd1, 8'd0);
                                e0_v = 1'b1;
                            end
                        end
                        vt52td_pkg::ESC_SHOW: hide_next = 1'b0;
                        vt52td_pkg::ESC_HIDE: hide_next = 1'b1;
                        vt52td_pkg::ESC_SAVE:
                        begin
                            saved_col_next = cx[7:0];
                            saved_row_next = cy[7:0];
                        end
                        vt52td_pkg::ESC_RESTORE:
                        begin
                            cx = {1'b0, saved_col_reg};
                            cy = {1'b0, saved_row_reg};
                        end
                        vt52td_pkg::ESC_CLR_LINE:
                        begin
                            cx   = 9'd0;
                            e0   = mk(vt52td_pkg::CMD_CLEAR_LINE, cy[7:0],
                                      8'd0, 8'd0, 8'd0, 8'd0);
                            e0_v = 1'b1;
                        end
                        vt52td_pkg::ESC_REV_ON:  rev_next  = 1'b1;
                        vt52td_pkg::ESC_REV_OFF: rev_next  = 1'b0;
                        vt52td_pkg::ESC_WRAP:    disc_next = 1'b0;
                        vt52td_pkg::ESC_NOWRAP:  disc_next = 1'b1;
                        default: ;
                    endcase
                end
                default: phase_next = PH_PLAIN;
            endcase
        end
        else if (char_code < vt52td_pkg::CH_SPACE || char_code == vt52td_pkg::CH_DEL)
        begin
            unique case (char_code) inside
                vt52td_pkg::CH_BEL:
                begin
                    e0   = mk(vt52td_pkg::CMD_BELL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                    e0_v = 1'b1;
                end
                vt52td_pkg::CH_BS, vt52td_pkg::CH_DEL:
                begin
                    if (cx != 9'd0)
                    begin
                        cx   = cx - 9'd1;
                        e0   = mk(vt52td_pkg::CMD_GLYPH, cy[7:0], 8'd0, cx[7:0], 8'd0,
                                  vt52td_pkg::CH_SPACE);
                        e0_v = 1'b1;
                    end
                end
                vt52td_pkg::CH_HT:
                    cx = (tab >= nc9) ? nc9 - 9'd1 : tab;
                vt52td_pkg::CH_LF:
                begin
                    cy = cy + 9'd1;
                    if (cy >= nr9)
                    begin
                        cy   = nr9 - 9'd1;
                        e0   = mk(vt52td_pkg::CMD_SCROLL_UP, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                        e0_v = 1'b1;
                    end
                end
                vt52td_pkg::CH_FF:
                begin
                    e0   = mk(vt52td_pkg::CMD_CLEAR_SCR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                    e0_v = 1'b1;
                    cx   = 9'd0;
                    cy   = 9'd0;
                end
                vt52td_pkg::CH_CR:  cx = 9'd0;
                vt52td_pkg::CH_ESC: phase_next = PH_ESC;
                default: ;
            endcase
        end
        else
        begin
            e0   = mk(vt52td_pkg::CMD_GLYPH, cy[7:0], 8'd0, cx[7:0], 8'd0, char_code);
            e0_v = 1'b1;
            cx   = cx + 9'd1;
        end

        // wrap or hold at line end, then scroll off the last row
        if (cx >= nc9)
        begin
            cx = nc9 - 9'd1;
            if (!disc_next)
            begin
                cx = 9'd0;
                cy = cy + 9'd1;
            end
        end
        if (cy >= nr9)
        begin
            cy   = nr9 - 9'd1;
            fs_v = 1'b1;
        end
        fin = mk(vt52td_pkg::CMD_SCROLL_UP, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);

        col_next = cx[7:0];
        row_next = cy[7:0];

        if (e0_v)
            s0 = e0;
        else if (e1_v)
            s0 = e1;
        else if (fs_v)
            s0 = fin;
        else
            s0 = mk(vt52td_pkg::CMD_NONE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        s1 = (e0_v && e1_v) ? e1 : fin;

        res.two = (e0_v && (e1_v || fs_v)) || (e1_v && fs_v);

        s0.cursor_col    = col_next;
        s0.cursor_row    = row_next;
        s0.reverse_video = rev_next;
        s0.cursor_hidden = hide_next;
        s0.last          = !res.two;
        s1.cursor_col    = col_next;
        s1.cursor_row    = row_next;
        s1.reverse_video = rev_next;
        s1.cursor_hidden = hide_next;
        s1.last          = 1'b1;

        res.first  = s0;
        res.second = s1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PLAIN;
            argcnt_reg    <= 2'd0;
            col_reg       <= 8'd0;
            row_reg       <= 8'd0;
            saved_col_reg <= 8'd0;
            saved_row_reg <= 8'd0;
            hide_reg      <= 1'b0;
            rev_reg       <= 1'b0;
            disc_reg      <= 1'b0;
            columns_reg   <= vt52td_pkg::COLS_RESET;
            rows_reg      <= vt52td_pkg::ROWS_RESET;
        end
        else if (step_en)
        begin
            phase_reg     <= phase_next;
            argcnt_reg    <= argcnt_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            saved_col_reg <= saved_col_next;
            saved_row_reg <= saved_row_next;
            hide_reg      <= hide_next;
            rev_reg       <= rev_next;
            disc_reg      <= disc_next;
        end
        else if (cfg.we)
        begin
            // pull the cursor and saved cursor into the new size
            case (cfg.index)
                vt52td_pkg::CFG_COLUMNS:
                begin
                    columns_reg <= cfg.data;
                    if (col_reg >= cfg_dim)
                        col_reg <= cfg_dim - 8'd1;
                    if (saved_col_reg >= cfg_dim)
                        saved_col_reg <= cfg_dim - 8'd1;
                end
                vt52td_pkg::CFG_ROWS:
                begin
                    rows_reg <= cfg.data;
                    if (row_reg >= cfg_dim)
                        row_reg <= cfg_dim - 8'd1;
                    if (saved_row_reg >= cfg_dim)
                        saved_row_reg <= cfg_dim - 8'd1;
                end
                default: ;
            endcase
        end
    end

    a_cursor_in_cols: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |-> res.first.cursor_col < nc)
        else $error("cursor column past line end");

    a_cursor_in_rows: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |-> res.first.cursor_row < nr)
        else $error("cursor row past last row");

    a_args_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && phase_reg == PH_ESC && char_code == vt52td_pkg::ESC_ADDR
        |=> phase_reg == PH_ARGS && argcnt_reg == 2'd0)
        else $error("cursor address did not start argument collection");

endmodule
